// ----- rtl/core/wlgb_pkg.sv -----
// Shared types and constants of the weighted least-used gateway balancer.
// Used by the table, ratio compare unit and the top level. No dependencies.
package wlgb_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [15:0] REG_PORT_RST = 16'd3000;
  localparam logic [15:0] TUN_PORT_RST = 16'd2152;
  localparam logic [63:0] STAMP_INIT   = 64'd9999;

  // Configuration register indexes (bit 2 of the byte address)
  localparam logic CFG_REG_PORT = 1'b0;
  localparam logic CFG_TUN_PORT = 1'b1;

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_FWD   = 2'd2;
  localparam logic [1:0] VERDICT_ABORT = 2'd3;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] weight;
    logic [15:0] port;
    logic [63:0] packets;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [15:0] dest_port;
    logic [15:0] src_port;
    logic [31:0] src_addr;
    logic [31:0] payload_word;
    logic [15:0] old_checksum;
    logic [63:0] now_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [2:0]  slot_index;
    logic        register_ok;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic [15:0] new_checksum;
  } out_t;

  typedef struct packed {
    logic done;
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ----- rtl/core/wlgb_table.sv -----
// Gateway table: one synchronous memory of entries, read through a registered output.
// Per-entry valid bits give the cleared-at-reset view. Uses wlgb_pkg.
module wlgb_table #(
  parameter int SLOTS = wlgb_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output wlgb_pkg::entry_t    rd_entry,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  wlgb_pkg::entry_t    wr_data
);

  wlgb_pkg::entry_t mem [SLOTS];
  wlgb_pkg::entry_t rd_q_r;
  logic [SLOTS-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written entries read as the cleared value
  assign rd_entry = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- rtl/core/wlgb_ratio.sv -----
// Multi-cycle exact compare of a*b against c*d (64x32 products, 96 bits).
// Two 32x32 multiplies per phase, low halves then high halves, then add, then compare. Uses wlgb_pkg.
module wlgb_ratio (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [31:0]         b,
  input  logic [63:0]         c,
  input  logic [31:0]         d,
  output wlgb_pkg::cmp_res_t  res
);

  logic [63:0] a_r, c_r;
  logic [31:0] b_r, d_r;
  logic [63:0] pl_r, ql_r, ph_r, qh_r;
  logic [95:0] ls_r, rs_r;
  logic        busy_r, busy_nxt;
  logic [1:0]  phase_r, phase_nxt;
  wlgb_pkg::cmp_res_t res_r, res_nxt;

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    res_nxt       = res_r;
    res_nxt.done  = 1'b0;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 2'd0;
    end else if (busy_r) begin
      phase_nxt = phase_r + 2'd1;
      if (phase_r == 2'd3) begin
        busy_nxt     = 1'b0;
        res_nxt.done = 1'b1;
        res_nxt.lt   = ls_r < rs_r;
        res_nxt.eq   = ls_r == rs_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 2'd0;
      res_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      c_r <= c;
      d_r <= d;
    end
    if (busy_r && phase_r == 2'd0) begin
      pl_r <= a_r[31:0] * b_r;
      ql_r <= c_r[31:0] * d_r;
    end
    if (busy_r && phase_r == 2'd1) begin
      ph_r <= a_r[63:32] * b_r;
      qh_r <= c_r[63:32] * d_r;
    end
    if (busy_r && phase_r == 2'd2) begin
      ls_r <= {ph_r, 32'd0} + {32'd0, pl_r};
      rs_r <= {qh_r, 32'd0} + {32'd0, ql_r};
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/core/weighted_least_used_gateway_balancer.sv -----
// Weighted least-used gateway balancer, top level.
// Input channel in_*: one classified UDP packet per beat (valid/stall).
// Result channel out_*: exactly one result beat per input beat, in order.
// Config port cfg_*: APB-style, register_port at 0x0, tunnel_port at 0x4.
// Registration packets take the first empty slot and are dropped; data
// packets pick the least-used gateway by packets/weight and are rewritten
// (aborted if no slot holds a gateway); all others pass. The gateway table
// sits in one synchronous memory that is scanned one slot per read, with a
// 96-bit ratio compare unit. Pass packets skip the table; registration
// reads and checks one slot at a time; data packets read each slot, run a
// ratio compare where needed, then read and write back the chosen slot.
// One packet is in work at a time; in_stall is high from acceptance until
// its result enters the output register. A stalled result holds in the
// output register while the next packet is accepted. Reset clears the
// table (per-slot valid bits, no sweep), the config registers to 3000 and
// 2152, and empties the output register.
module weighted_least_used_gateway_balancer #(
  parameter int SLOTS = wlgb_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wlgb_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wlgb_pkg::out_t     out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_EV     = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_UPD_RD = 3'd4;
  localparam logic [2:0] ST_UPD_WR = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [2:0]  state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic        have_r, have_nxt;
  logic        is_reg_r, is_reg_nxt;
  logic [63:0] bp_r, bp_nxt, blu_r, blu_nxt;
  logic [31:0] bw_r, bw_nxt;
  logic [63:0] cur_pk_r, cur_pk_nxt, cur_lu_r, cur_lu_nxt;
  logic [31:0] cur_w_r, cur_w_nxt;
  wlgb_pkg::in_t  item_r, item_nxt;
  wlgb_pkg::out_t res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] reg_port_r, tun_port_r;

  logic              tbl_rd_en, tbl_wr_en;
  logic [IW-1:0]     tbl_rd_addr, tbl_wr_addr;
  wlgb_pkg::entry_t  tbl_rd, tbl_wr_data;
  logic              cmp_start;
  wlgb_pkg::cmp_res_t cmp_res;

  logic        cfg_wr;
  logic        empty, is_last;
  logic [31:0] w_eff;
  logic [15:0] inv_ock, inv_sport, inv_dport;
  logic [18:0] cs0;
  logic [16:0] cs1;
  logic [15:0] cs2;

  wlgb_table #(.SLOTS(SLOTS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (tbl_rd_en),
    .rd_addr  (tbl_rd_addr),
    .rd_entry (tbl_rd),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_wr_addr),
    .wr_data  (tbl_wr_data)
  );

  wlgb_ratio u_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .a     (tbl_rd.packets),
    .b     (bw_r),
    .c     (bp_r),
    .d     (w_eff),
    .res   (cmp_res)
  );

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {16'd0, (cfg_paddr[2] == wlgb_pkg::CFG_TUN_PORT) ?
                              tun_port_r : reg_port_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_port_r <= wlgb_pkg::REG_PORT_RST;
      tun_port_r <= wlgb_pkg::TUN_PORT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == wlgb_pkg::CFG_REG_PORT) begin
        reg_port_r <= cfg_pwdata[15:0];
      end else begin
        tun_port_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign empty   = tbl_rd.addr == 32'd0;
  assign is_last = idx_r == LAST_IDX;
  assign w_eff   = (tbl_rd.weight == 32'd0) ? 32'd1 : tbl_rd.weight;

  // incremental checksum, 16-bit ones' complement terms
  assign inv_ock   = ~item_r.old_checksum;
  assign inv_sport = ~item_r.src_port;
  assign inv_dport = ~item_r.dest_port;
  assign cs0 = {3'd0, inv_ock} + {3'd0, inv_sport} + {3'd0, reg_port_r}
             + {3'd0, inv_dport} + {3'd0, tbl_rd.port};
  assign cs1 = {1'b0, cs0[15:0]} + {14'd0, cs0[18:16]};
  assign cs2 = cs1[15:0] + {15'd0, cs1[16]};

  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    logic adv;
    logic take;
    adv           = 1'b0;
    take          = 1'b0;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    is_reg_nxt    = is_reg_r;
    bp_nxt        = bp_r;
    bw_nxt        = bw_r;
    blu_nxt       = blu_r;
    cur_pk_nxt    = cur_pk_r;
    cur_w_nxt     = cur_w_r;
    cur_lu_nxt    = cur_lu_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    tbl_rd_en     = 1'b0;
    tbl_rd_addr   = idx_r;
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = idx_r;
    tbl_wr_data   = tbl_rd;
    cmp_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt  = '0;
          have_nxt = 1'b0;
          res_nxt  = '0;
          if (in_data.dest_port == reg_port_r) begin
            is_reg_nxt       = 1'b1;
            res_nxt.verdict  = wlgb_pkg::VERDICT_DROP;
            state_nxt        = ST_RD;
          end else if (in_data.dest_port == tun_port_r) begin
            is_reg_nxt = 1'b0;
            state_nxt  = ST_RD;
          end else begin
            res_nxt.verdict = wlgb_pkg::VERDICT_PASS;
            state_nxt       = ST_FIN;
          end
        end
      end
      ST_RD: begin
        tbl_rd_en = 1'b1;
        state_nxt = ST_EV;
      end
      ST_EV: begin
        if (is_reg_r) begin
          if (empty) begin
            tbl_wr_en             = 1'b1;
            tbl_wr_data.addr      = item_r.src_addr;
            tbl_wr_data.weight    = item_r.payload_word;
            tbl_wr_data.port      = item_r.src_port;
            tbl_wr_data.packets   = 64'd0;
            tbl_wr_data.stamp     = wlgb_pkg::STAMP_INIT;
            res_nxt.slot_index    = 3'(idx_r);
            res_nxt.register_ok   = 1'b1;
            state_nxt             = ST_FIN;
          end else if (is_last) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end else if (empty) begin
          adv = 1'b1;
        end else if (tbl_rd.packets == 64'd0) begin
          // unused gateway wins at once
          best_nxt  = idx_r;
          have_nxt  = 1'b1;
          state_nxt = ST_UPD_RD;
        end else if (!have_r) begin
          best_nxt = idx_r;
          have_nxt = 1'b1;
          bp_nxt   = tbl_rd.packets;
          bw_nxt   = w_eff;
          blu_nxt  = tbl_rd.stamp;
          adv      = 1'b1;
        end else begin
          cmp_start  = 1'b1;
          cur_pk_nxt = tbl_rd.packets;
          cur_w_nxt  = w_eff;
          cur_lu_nxt = tbl_rd.stamp;
          state_nxt  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (cmp_res.done) begin
          take = cmp_res.lt || (cmp_res.eq && (cur_lu_r < blu_r));
          if (take) begin
            best_nxt = idx_r;
            bp_nxt   = cur_pk_r;
            bw_nxt   = cur_w_r;
            blu_nxt  = cur_lu_r;
          end
          adv = 1'b1;
        end
      end
      ST_UPD_RD: begin
        tbl_rd_en   = 1'b1;
        tbl_rd_addr = best_r;
        state_nxt   = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        tbl_wr_en             = 1'b1;
        tbl_wr_addr           = best_r;
        tbl_wr_data.packets   = tbl_rd.packets + 64'd1;
        tbl_wr_data.stamp     = item_r.now_time;
        res_nxt.verdict       = wlgb_pkg::VERDICT_FWD;
        res_nxt.slot_index    = 3'(best_r);
        res_nxt.register_ok   = 1'b0;
        res_nxt.new_src_port  = reg_port_r;
        res_nxt.new_dst_port  = tbl_rd.port;
        res_nxt.new_checksum  = ~cs2;
        state_nxt             = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // step to the next slot, or close the scan
    if (adv) begin
      if (!is_last) begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_RD;
      end else if (have_nxt) begin
        state_nxt = ST_UPD_RD;
      end else begin
        res_nxt         = '0;
        res_nxt.verdict = wlgb_pkg::VERDICT_ABORT;
        state_nxt       = ST_FIN;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      is_reg_r    <= 1'b0;
      idx_r       <= '0;
      best_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      is_reg_r    <= is_reg_nxt;
      idx_r       <= idx_nxt;
      best_r      <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bp_r     <= bp_nxt;
    bw_r     <= bw_nxt;
    blu_r    <= blu_nxt;
    cur_pk_r <= cur_pk_nxt;
    cur_w_r  <= cur_w_nxt;
    cur_lu_r <= cur_lu_nxt;
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cmp_only_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_res.done |-> state_r == ST_CMP)
    else $error("ratio result arrived outside the compare state");

  a_tbl_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr_en |-> (state_r == ST_EV || state_r == ST_UPD_WR))
    else $error("table written outside registration or update");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished result not loaded into output register");

  a_no_rewrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.verdict != wlgb_pkg::VERDICT_FWD) |->
      (out_r.new_checksum == 16'd0 && out_r.new_dst_port == 16'd0 &&
       out_r.new_src_port == 16'd0))
    else $error("rewrite fields set on a non-forward result");

endmodule
